// ===== design/fspd_pkg.sv =====
// Package for the flywheel stroke phase detector: codes, reset values, queue entry type.
// Used by fspd_front, fspd_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package fspd_pkg;

    localparam int WINDOW_LEN_DEF = 6;

    localparam logic [19:0] MIN_INTERVAL_RST = 20'd7000;
    localparam logic [23:0] STOP_INTERVAL_RST = 24'd300000;
    localparam logic [23:0] STROKE_MIN_RST = 24'd200000;
    localparam logic [3:0]  CHANGE_THR_RST = 4'd4;
    localparam logic [26:0] MAX_RECOVERY_RST = 27'd6000000;
    localparam logic [31:0] DRAG_GAIN_RST = 32'd836516315;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
    localparam logic [2:0] REG_STOP_INTERVAL = 3'd1;
    localparam logic [2:0] REG_STROKE_MIN = 3'd2;
    localparam logic [2:0] REG_CHANGE_THR = 3'd3;
    localparam logic [2:0] REG_MAX_RECOVERY = 3'd4;
    localparam logic [2:0] REG_DRAG_GAIN = 3'd5;

    localparam logic [1:0] VERDICT_OK = 2'd0;
    localparam logic [1:0] VERDICT_SHORT = 2'd1;
    localparam logic [1:0] VERDICT_JUMP = 2'd2;

    localparam logic [1:0] PH_STOPPED = 2'd0;
    localparam logic [1:0] PH_DRIVE = 2'd1;
    localparam logic [1:0] PH_RECOVERY = 2'd2;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] now;
        logic [31:0] cur;
    } fspd_cmd_t;

endpackage

// ===== design/fspd_front.sv =====
// Front part: accepts timestamps, computes the interval and classifies it, then queues the word.
// Depends on fspd_pkg.
`timescale 1ns / 1ps

module fspd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           timestamp_us,
    input  logic [19:0]           min_interval_us,
    output logic                  q_valid,
    output fspd_pkg::fspd_cmd_t   q_data,
    input  logic                  q_pop
);

    fspd_pkg::fspd_cmd_t q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    // raw time of the last OK word, and the prior interval; only the front needs them
    logic [31:0] last_raw_reg, prior_reg;
    logic [31:0] cur, diff;
    logic        push;
    fspd_pkg::fspd_cmd_t word;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = q_mem_reg[rd_ptr_reg];

    // classify the interval
    always_comb
    begin
        cur = timestamp_us - last_raw_reg;
        diff = (cur > prior_reg) ? cur - prior_reg : prior_reg - cur;
        word.now = timestamp_us;
        word.cur = cur;
        if (cur < {12'd0, min_interval_us})
            word.verdict = fspd_pkg::VERDICT_SHORT;
        else if (diff > cur)
            word.verdict = fspd_pkg::VERDICT_JUMP;
        else
            word.verdict = fspd_pkg::VERDICT_OK;
    end

    // hold queue entries
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= word;
    end

    // advance pointers and interval history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
            last_raw_reg <= 32'd0;
            prior_reg <= 32'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
                if (word.verdict != fspd_pkg::VERDICT_SHORT)
                    prior_reg <= cur;
                if (word.verdict == fspd_pkg::VERDICT_OK)
                    last_raw_reg <= timestamp_us;
            end
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ===== design/fspd_div.sv =====
// Serial restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Saturates when the quotient needs more than 32 bits. Depends on nothing.
`timescale 1ns / 1ps

module fspd_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [32:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg, sat_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign done = done_reg;
    assign quotient = sat_reg ? 32'hFFFF_FFFF : dvd_reg[31:0];

    always_comb
    begin
        shifted = {rem_reg[31:0], dvd_reg[63]};
        trial = shifted - {1'b0, dvs_reg};
    end

    // step one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 7'd0;
            sat_reg <= 1'b0;
            rem_reg <= 33'd0;
            dvd_reg <= 64'd0;
            dvs_reg <= 32'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd0;
                rem_reg <= 33'd0;
                dvd_reg <= dividend;
                dvs_reg <= divisor;
                sat_reg <= (divisor == 32'd0) || (dividend[63:32] >= divisor);
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[62:0], ~trial[32]};
                rem_reg <= trial[32] ? shifted : trial;
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/fspd_back.sv =====
// Back part: window, phase machine, counters and drag update through the serial divider.
// Depends on fspd_pkg and fspd_div.
`timescale 1ns / 1ps

module fspd_back #(
    parameter int WINDOW_LEN = fspd_pkg::WINDOW_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  fspd_pkg::fspd_cmd_t   q_data,
    output logic                  q_pop,
    input  logic [23:0]           stop_interval_us,
    input  logic [23:0]           stroke_min_drive_us,
    input  logic [3:0]            change_threshold,
    input  logic [26:0]           max_recovery_us,
    input  logic [31:0]           drag_gain,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            verdict,
    output logic [1:0]            phase,
    output logic [31:0]           rev_count,
    output logic [31:0]           last_rev_time,
    output logic [15:0]           stroke_count,
    output logic [31:0]           last_stroke_time,
    output logic [31:0]           newest_interval,
    output logic [31:0]           drag_value
);

    localparam int CW = $clog2(WINDOW_LEN);

    typedef enum logic [1:0] { S_IDLE, S_MUL, S_DIV, S_OUT } st_t;

    st_t st_reg;
    logic [31:0] win_reg [WINDOW_LEN];
    logic [1:0]  phase_reg, verdict_reg;
    logic [31:0] drive_start_reg, drive_len_reg, rec_start_reg, rec_int_reg, rec_len_reg;
    logic [31:0] revs_reg, rev_time_reg, stroke_time_reg, drag_reg;
    logic [15:0] strokes_reg;
    logic [31:0] diff_reg, dur_reg;
    logic [63:0] prod_reg;
    logic        div_start_reg;
    logic        div_done;
    logic [31:0] div_q;

    logic [31:0] nw [WINDOW_LEN];
    logic [CW:0] acc_cnt, dec_cnt;
    logic        any_zero, unpowered, powered;
    logic [31:0] now, cur;

    assign now = q_data.now;
    assign cur = q_data.cur;
    assign q_pop = (st_reg == S_IDLE) && q_valid;
    assign out_valid = (st_reg == S_OUT);
    assign verdict = verdict_reg;
    assign phase = phase_reg;
    assign rev_count = revs_reg;
    assign last_rev_time = rev_time_reg;
    assign stroke_count = strokes_reg;
    assign last_stroke_time = stroke_time_reg;
    assign newest_interval = win_reg[0];
    assign drag_value = drag_reg;

    // shifted window and pair counts on it
    always_comb
    begin
        nw[0] = cur;
        for (int i = 1; i < WINDOW_LEN; i++)
            nw[i] = win_reg[i - 1];
        acc_cnt = '0;
        dec_cnt = '0;
        any_zero = 1'b0;
        for (int i = 0; i < WINDOW_LEN; i++)
            if (nw[i] == 32'd0)
                any_zero = 1'b1;
        for (int i = 1; i < WINDOW_LEN; i++)
        begin
            if (nw[i] >= nw[i - 1])
                acc_cnt = acc_cnt + 1'b1;
            else
                dec_cnt = dec_cnt + 1'b1;
        end
        unpowered = ({{(32 - CW - 1){1'b0}}, acc_cnt} < {28'd0, change_threshold});
        powered = ({{(32 - CW - 1){1'b0}}, dec_cnt} < {28'd0, change_threshold});
    end

    fspd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // run one word through the phase machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            for (int i = 0; i < WINDOW_LEN; i++)
                win_reg[i] <= 32'd0;
            phase_reg <= fspd_pkg::PH_STOPPED;
            verdict_reg <= fspd_pkg::VERDICT_OK;
            drive_start_reg <= 32'd0;
            drive_len_reg <= 32'd0;
            rec_start_reg <= 32'd0;
            rec_int_reg <= 32'd0;
            rec_len_reg <= 32'd0;
            revs_reg <= 32'd0;
            rev_time_reg <= 32'd0;
            strokes_reg <= 16'd0;
            stroke_time_reg <= 32'd0;
            drag_reg <= 32'd0;
            diff_reg <= 32'd0;
            dur_reg <= 32'd0;
            prod_reg <= 64'd0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        verdict_reg <= q_data.verdict;
                        st_reg <= S_OUT;
                        if (q_data.verdict == fspd_pkg::VERDICT_OK)
                        begin
                            for (int i = 0; i < WINDOW_LEN; i++)
                                win_reg[i] <= nw[i];
                            if (phase_reg == fspd_pkg::PH_RECOVERY
                                && cur > {8'd0, stop_interval_us})
                            begin
                                phase_reg <= fspd_pkg::PH_STOPPED;
                                rec_start_reg <= 32'd0;
                                rec_int_reg <= 32'd0;
                                rec_len_reg <= 32'd0;
                                drive_start_reg <= 32'd0;
                                drive_len_reg <= 32'd0;
                            end
                            else if (phase_reg == fspd_pkg::PH_STOPPED)
                            begin
                                if (!any_zero && !unpowered)
                                begin
                                    phase_reg <= fspd_pkg::PH_DRIVE;
                                    drive_start_reg <= now - cur;
                                    rev_time_reg <= now;
                                    revs_reg <= revs_reg + 32'd1;
                                end
                            end
                            else if (phase_reg == fspd_pkg::PH_DRIVE)
                            begin
                                rev_time_reg <= now;
                                revs_reg <= revs_reg + 32'd1;
                                if (unpowered)
                                begin
                                    if (drive_len_reg > {8'd0, stroke_min_drive_us})
                                    begin
                                        strokes_reg <= strokes_reg + 16'd1;
                                        stroke_time_reg <= now;
                                    end
                                    phase_reg <= fspd_pkg::PH_RECOVERY;
                                    rec_start_reg <= now - cur;
                                    rec_int_reg <= cur;
                                    drive_len_reg <= 32'd0;
                                end
                                else
                                    drive_len_reg <= now - drive_start_reg;
                            end
                            else if (phase_reg == fspd_pkg::PH_RECOVERY)
                            begin
                                rev_time_reg <= now;
                                revs_reg <= revs_reg + 32'd1;
                                if (powered)
                                begin
                                    if (rec_int_reg < nw[WINDOW_LEN - 1]
                                        && rec_len_reg < {5'd0, max_recovery_us})
                                    begin
                                        diff_reg <= nw[WINDOW_LEN - 1] - rec_int_reg;
                                        dur_reg <= rec_len_reg;
                                        st_reg <= S_MUL;
                                    end
                                    phase_reg <= fspd_pkg::PH_DRIVE;
                                    drive_start_reg <= now - cur;
                                    rec_len_reg <= 32'd0;
                                end
                                else
                                    rec_len_reg <= now - rec_start_reg;
                            end
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg <= {32'd0, drag_gain} * {32'd0, diff_reg};
                    div_start_reg <= 1'b1;
                    st_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        drag_reg <= div_q;
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/flywheel_stroke_phase_detector_core.sv =====
// Top level of the flywheel stroke phase detector: configuration registers, front and back.
// Depends on fspd_pkg, fspd_front, fspd_back, fspd_div.
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_stall    timestamp_us
//   result    out        out_valid/out_stall  verdict..drag_value
//   config    in         APB write/read       six registers at 4*i
//
// A word passes the back part as take, then present; when the drag factor is updated at
// the end of a recovery it goes through the product, the start of the serial divider,
// the quotient bits at one a cycle, the collection of the quotient, then present.
// Reset is asynchronous and restores all registers and state at once, but for the queue entries.
// A two-word queue lets the front keep accepting until it is full while the result waits on out_stall.
`timescale 1ns / 1ps

module flywheel_stroke_phase_detector_core #(
    parameter int WINDOW_LEN = fspd_pkg::WINDOW_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] timestamp_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic [1:0]  phase,
    output logic [31:0] rev_count,
    output logic [31:0] last_rev_time,
    output logic [15:0] stroke_count,
    output logic [31:0] last_stroke_time,
    output logic [31:0] newest_interval,
    output logic [31:0] drag_value
);

    logic [19:0] min_int_reg;
    logic [23:0] stop_int_reg, stroke_min_reg;
    logic [3:0]  thr_reg;
    logic [26:0] max_rec_reg;
    logic [31:0] gain_reg;
    logic [2:0]  idx;
    logic        wr;
    logic        q_valid, q_pop;
    fspd_pkg::fspd_cmd_t q_data;

    assign pready = 1'b1;
    assign idx = paddr[4:2];
    assign wr = psel && penable && pwrite;

    // read back registers
    always_comb
    begin
        case (idx)
            fspd_pkg::REG_MIN_INTERVAL:  prdata = {12'd0, min_int_reg};
            fspd_pkg::REG_STOP_INTERVAL: prdata = {8'd0, stop_int_reg};
            fspd_pkg::REG_STROKE_MIN:    prdata = {8'd0, stroke_min_reg};
            fspd_pkg::REG_CHANGE_THR:    prdata = {28'd0, thr_reg};
            fspd_pkg::REG_MAX_RECOVERY:  prdata = {5'd0, max_rec_reg};
            fspd_pkg::REG_DRAG_GAIN:     prdata = gain_reg;
            default:                     prdata = 32'd0;
        endcase
    end

    // write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_int_reg <= fspd_pkg::MIN_INTERVAL_RST;
            stop_int_reg <= fspd_pkg::STOP_INTERVAL_RST;
            stroke_min_reg <= fspd_pkg::STROKE_MIN_RST;
            thr_reg <= fspd_pkg::CHANGE_THR_RST;
            max_rec_reg <= fspd_pkg::MAX_RECOVERY_RST;
            gain_reg <= fspd_pkg::DRAG_GAIN_RST;
        end
        else if (wr)
        begin
            case (idx)
                fspd_pkg::REG_MIN_INTERVAL:  min_int_reg <= pwdata[19:0];
                fspd_pkg::REG_STOP_INTERVAL: stop_int_reg <= pwdata[23:0];
                fspd_pkg::REG_STROKE_MIN:    stroke_min_reg <= pwdata[23:0];
                fspd_pkg::REG_CHANGE_THR:    thr_reg <= pwdata[3:0];
                fspd_pkg::REG_MAX_RECOVERY:  max_rec_reg <= pwdata[26:0];
                fspd_pkg::REG_DRAG_GAIN:     gain_reg <= pwdata;
                default:                     ;
            endcase
        end
    end

    fspd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .timestamp_us    (timestamp_us),
        .min_interval_us (min_int_reg),
        .q_valid         (q_valid),
        .q_data          (q_data),
        .q_pop           (q_pop)
    );

    fspd_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_valid             (q_valid),
        .q_data              (q_data),
        .q_pop               (q_pop),
        .stop_interval_us    (stop_int_reg),
        .stroke_min_drive_us (stroke_min_reg),
        .change_threshold    (thr_reg),
        .max_recovery_us     (max_rec_reg),
        .drag_gain           (gain_reg),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .verdict             (verdict),
        .phase               (phase),
        .rev_count           (rev_count),
        .last_rev_time       (last_rev_time),
        .stroke_count        (stroke_count),
        .last_stroke_time    (last_stroke_time),
        .newest_interval     (newest_interval),
        .drag_value          (drag_value)
    );

endmodule

// ===== bench/flywheel_stroke_phase_detector_core_tb.sv =====
// Testbench for the flywheel stroke phase detector core: directed table, then random impulses.
// Depends on fspd_pkg and flywheel_stroke_phase_detector_core; self-checking via its own model.
`timescale 1ns / 1ps

module flywheel_stroke_phase_detector_core_tb;

    localparam int WIN = fspd_pkg::WINDOW_LEN_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  phase;
        logic [31:0] rev_count;
        logic [31:0] last_rev_time;
        logic [15:0] stroke_count;
        logic [31:0] last_stroke_time;
        logic [31:0] newest_interval;
        logic [31:0] drag_value;
    } snapshot_t;

    // directed row: timestamp, and optionally a typed expectation of verdict and phase
    typedef struct {
        logic [31:0] ts;
        bit          typed;
        logic [1:0]  verdict;
        logic [1:0]  phase;
    } impulse_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] timestamp_us = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  verdict;
    logic [1:0]  phase;
    logic [31:0] rev_count;
    logic [31:0] last_rev_time;
    logic [15:0] stroke_count;
    logic [31:0] last_stroke_time;
    logic [31:0] newest_interval;
    logic [31:0] drag_value;

    flywheel_stroke_phase_detector_core dut (.*);

    always #5 clk = ~clk;

    // predictor state and configuration
    logic [31:0] m_min_iv, m_stop_iv, m_stroke_min, m_thr, m_max_rec, m_gain;
    logic [31:0] win_q [WIN];
    logic [31:0] last_raw, prior_iv, drv_start, drv_len, rec_start, rec_start_iv, rec_len;
    logic [31:0] revs, rev_t, stroke_t, drag;
    logic [15:0] strokes;
    logic [1:0]  cur_phase;

    snapshot_t expected_snaps[$];
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned cycles = 0;
    bit quiet_tail = 1'b0;
    bit long_hold = 1'b0;
    int unsigned drag_updates = 0;
    int unsigned stroke_events = 0;

    task automatic predictor_reset();
        m_min_iv = 32'(fspd_pkg::MIN_INTERVAL_RST);
        m_stop_iv = 32'(fspd_pkg::STOP_INTERVAL_RST);
        m_stroke_min = 32'(fspd_pkg::STROKE_MIN_RST);
        m_thr = 32'(fspd_pkg::CHANGE_THR_RST);
        m_max_rec = 32'(fspd_pkg::MAX_RECOVERY_RST);
        m_gain = fspd_pkg::DRAG_GAIN_RST;
        foreach (win_q[i]) win_q[i] = '0;
        {last_raw, prior_iv, drv_start, drv_len, rec_start, rec_start_iv, rec_len} = '0;
        {revs, rev_t, stroke_t, drag} = '0;
        strokes = '0;
        cur_phase = fspd_pkg::PH_STOPPED;
    endtask

    function automatic int unsigned pair_count(bit accel);
        int unsigned n;
        n = 0;
        for (int i = 1; i < WIN; i++)
            if ((win_q[i] >= win_q[i-1]) == accel) n++;
        return n;
    endfunction

    function automatic logic [31:0] drag_quotient(logic [31:0] dif, logic [31:0] dur);
        logic [63:0] q;
        if (dur == 0) return 32'hFFFF_FFFF;
        q = (64'(m_gain) * 64'(dif)) / 64'(dur);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // advance the phase machine by one impulse; returns verdict
    function automatic logic [1:0] impulse_advance(logic [31:0] now);
        logic [31:0] cur, dif, ending;
        cur = now - last_raw;
        if (cur < m_min_iv) return fspd_pkg::VERDICT_SHORT;
        dif = (cur > prior_iv) ? cur - prior_iv : prior_iv - cur;
        prior_iv = cur;
        if (dif > cur) return fspd_pkg::VERDICT_JUMP;
        for (int i = WIN - 1; i > 0; i--) win_q[i] = win_q[i-1];
        win_q[0] = cur;
        last_raw = now;
        if (cur_phase == fspd_pkg::PH_RECOVERY && cur > m_stop_iv)
        begin
            cur_phase = fspd_pkg::PH_STOPPED;
            {rec_start, rec_start_iv, rec_len, drv_start, drv_len} = '0;
            return fspd_pkg::VERDICT_OK;
        end
        if (cur_phase == fspd_pkg::PH_STOPPED)
        begin
            foreach (win_q[i]) if (win_q[i] == 0) return fspd_pkg::VERDICT_OK;
            if (pair_count(1) < m_thr) return fspd_pkg::VERDICT_OK;
            cur_phase = fspd_pkg::PH_DRIVE;
            drv_start = now - win_q[0];
            rev_t = now;
            revs++;
            return fspd_pkg::VERDICT_OK;
        end
        if (cur_phase != fspd_pkg::PH_DRIVE && cur_phase != fspd_pkg::PH_RECOVERY)
            return fspd_pkg::VERDICT_OK;
        rev_t = now;
        revs++;
        if (cur_phase == fspd_pkg::PH_DRIVE)
        begin
            if (pair_count(1) < m_thr)
            begin
                if (drv_len > m_stroke_min)
                begin
                    strokes++;
                    stroke_t = now;
                    stroke_events++;
                end
                cur_phase = fspd_pkg::PH_RECOVERY;
                rec_start = now - win_q[0];
                rec_start_iv = win_q[0];
                drv_len = '0;
            end
            else
                drv_len = now - drv_start;
            return fspd_pkg::VERDICT_OK;
        end
        if (pair_count(0) < m_thr)
        begin
            ending = win_q[WIN-1];
            if (rec_start_iv < ending && rec_len < m_max_rec)
            begin
                drag = drag_quotient(ending - rec_start_iv, rec_len);
                drag_updates++;
            end
            cur_phase = fspd_pkg::PH_DRIVE;
            drv_start = now - win_q[0];
            rec_len = '0;
        end
        else
            rec_len = now - rec_start;
        return fspd_pkg::VERDICT_OK;
    endfunction

    function automatic snapshot_t impulse_snapshot(logic [31:0] now);
        snapshot_t s;
        s.verdict = impulse_advance(now);
        s.phase = cur_phase;
        s.rev_count = revs;
        s.last_rev_time = rev_t;
        s.stroke_count = strokes;
        s.last_stroke_time = stroke_t;
        s.newest_interval = win_q[0];
        s.drag_value = drag;
        return s;
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off
    initial
    begin : result_stall
        int unsigned n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s exp %0d got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // compare each result word against the predictor
    always @(posedge clk)
    begin : result_check
        snapshot_t e, got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{verdict, phase, rev_count, last_rev_time, stroke_count,
                    last_stroke_time, newest_interval, drag_value};
            results_seen++;
            if (expected_snaps.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_snaps.pop_front();
                check_field("verdict", 32'(e.verdict), 32'(got.verdict));
                check_field("phase", 32'(e.phase), 32'(got.phase));
                check_field("rev_count", e.rev_count, got.rev_count);
                check_field("last_rev_time", e.last_rev_time, got.last_rev_time);
                check_field("stroke_count", 32'(e.stroke_count), 32'(got.stroke_count));
                check_field("last_stroke_time", e.last_stroke_time, got.last_stroke_time);
                check_field("newest_interval", e.newest_interval, got.newest_interval);
                check_field("drag_value", e.drag_value, got.drag_value);
            end
        end
    end

    // setup then access cycle; mirror into predictor
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fspd_pkg::REG_MIN_INTERVAL:  m_min_iv = val & 32'hF_FFFF;
            fspd_pkg::REG_STOP_INTERVAL: m_stop_iv = val & 32'hFF_FFFF;
            fspd_pkg::REG_STROKE_MIN:    m_stroke_min = val & 32'hFF_FFFF;
            fspd_pkg::REG_CHANGE_THR:    m_thr = val & 32'hF;
            fspd_pkg::REG_MAX_RECOVERY:  m_max_rec = val & 32'h7FF_FFFF;
            fspd_pkg::REG_DRAG_GAIN:     m_gain = val;
            default: ;
        endcase
    endtask

    // offer one word, hold until accepted, with optional random gap first
    task automatic send_impulse(logic [31:0] ts, bit gaps);
        if (gaps && !quiet_tail && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        expected_snaps.push_back(impulse_snapshot(ts));
        in_valid <= 1'b1;
        timestamp_us <= ts;
        do @(posedge clk); while (in_stall);
    endtask

    // drop valid and wait for every expected result
    task automatic drain_idle();
        in_valid <= 1'b0;
        while (expected_snaps.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // rowing-like stroke: accelerating drive then decelerating recovery, some noise
    task automatic row_strokes(int unsigned n, ref logic [31:0] t);
        int unsigned iv, n_drive, n_rec;
        for (int s = 0; s < n; s++)
        begin
            iv = $urandom_range(30000, 60000);
            n_drive = $urandom_range(6, 14);
            n_rec = $urandom_range(8, 20);
            for (int k = 0; k < n_drive; k++)
            begin
                iv = iv - iv / $urandom_range(8, 30);
                if (iv < 8000) iv = 8000;
                t += iv;
                send_impulse(t, 1);
            end
            for (int k = 0; k < n_rec; k++)
            begin
                iv = iv + iv / $urandom_range(10, 40);
                t += iv;
                send_impulse(t, 1);
            end
            case ($urandom_range(0, 15))
                0: send_impulse(t + $urandom_range(0, 5000), 1);
                1: send_impulse(t + iv * 3, 1);
                2: send_impulse($urandom(), 1);
                3:
                begin
                    t += 400000;
                    send_impulse(t, 1);
                end
                default: ;
            endcase
        end
    endtask

    impulse_row_t directed[] = '{
        '{32'd0,          1, fspd_pkg::VERDICT_SHORT, fspd_pkg::PH_STOPPED},
        '{32'd6999,       1, fspd_pkg::VERDICT_SHORT, fspd_pkg::PH_STOPPED},
        '{32'd7000,       1, fspd_pkg::VERDICT_OK,    fspd_pkg::PH_STOPPED},
        '{32'd14000,      1, fspd_pkg::VERDICT_OK,    fspd_pkg::PH_STOPPED},
        '{32'd40000,      1, fspd_pkg::VERDICT_OK,    fspd_pkg::PH_STOPPED},
        '{32'd49000,      1, fspd_pkg::VERDICT_JUMP,  fspd_pkg::PH_STOPPED},
        '{32'd47000,      0, 0, 0},
        '{32'd54000,      0, 0, 0},
        '{32'd61000,      0, 0, 0},
        '{32'd67000,      0, 0, 0},
        '{32'd72000,      0, 0, 0},
        '{32'd76500,      0, 0, 0},
        '{32'd80500,      0, 0, 0},
        '{32'hFFFF_FFFF,  0, 0, 0},
        '{32'h0000_1000,  0, 0, 0},
        '{32'hFFFF_0000,  0, 0, 0},
        '{32'h8000_0000,  0, 0, 0},
        '{32'h8001_0000,  0, 0, 0},
        '{32'h8002_0000,  0, 0, 0}
    };

    initial
    begin : stimulus
        logic [31:0] t;
        snapshot_t e;
        predictor_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (directed[i])
        begin
            send_impulse(directed[i].ts, 0);
            e = expected_snaps[$];
            if (directed[i].typed && (e.verdict !== directed[i].verdict
                                      || e.phase !== directed[i].phase))
            begin
                $error("table row %0d verdict exp %0d pred %0d, phase exp %0d pred %0d", i,
                       directed[i].verdict, e.verdict, directed[i].phase, e.phase);
                errors++;
            end
        end
        drain_idle();

        // extreme settings: zero minimum, all-ones gain, zero threshold phase
        reg_write(fspd_pkg::REG_MIN_INTERVAL, 32'd0);
        reg_write(fspd_pkg::REG_DRAG_GAIN, 32'hFFFF_FFFF);
        reg_write(fspd_pkg::REG_MAX_RECOVERY, 32'h7FF_FFFF);
        reg_write(fspd_pkg::REG_STOP_INTERVAL, 32'hFF_FFFF);
        reg_write(fspd_pkg::REG_STROKE_MIN, 32'd0);
        reg_write(fspd_pkg::REG_CHANGE_THR, 32'd15);
        t = 32'h8002_0000;
        send_impulse(t, 0);
        send_impulse(t, 0);
        row_strokes(16, t);
        drain_idle();
        reg_write(fspd_pkg::REG_CHANGE_THR, 32'd0);
        row_strokes(4, t);
        drain_idle();
        reg_write(fspd_pkg::REG_MIN_INTERVAL, 32'hF_FFFF);
        for (int k = 0; k < 6; k++) send_impulse($urandom(), 1);
        drain_idle();

        // reset-like values, long receiver hold-off while sender keeps going
        reg_write(fspd_pkg::REG_MIN_INTERVAL, 32'd7000);
        reg_write(fspd_pkg::REG_CHANGE_THR, 32'd4);
        reg_write(fspd_pkg::REG_STOP_INTERVAL, 32'd300000);
        reg_write(fspd_pkg::REG_STROKE_MIN, 32'd200000);
        reg_write(fspd_pkg::REG_MAX_RECOVERY, 32'd6000000);
        reg_write(fspd_pkg::REG_DRAG_GAIN, 32'd836516315);
        long_hold = 1'b1;
        row_strokes(6, t);
        // sender pauses for the whole backlog
        drain_idle();

        // random main body over a range of settings
        for (int ph = 0; ph < 7; ph++)
        begin
            reg_write(fspd_pkg::REG_MIN_INTERVAL, $urandom_range(0, 12000));
            reg_write(fspd_pkg::REG_CHANGE_THR, $urandom_range(1, 7));
            reg_write(fspd_pkg::REG_STROKE_MIN, $urandom_range(0, 400000));
            reg_write(fspd_pkg::REG_MAX_RECOVERY,
                      ph == 3 ? 32'd0 : $urandom_range(100000, 8000000));
            reg_write(fspd_pkg::REG_DRAG_GAIN, $urandom());
            reg_write(fspd_pkg::REG_STOP_INTERVAL, $urandom_range(100000, 500000));
            if (ph == 6) quiet_tail = 1'b1;
            row_strokes(7, t);
            drain_idle();
        end

        $display("covered %0d results, %0d stroke events, %0d drag updates",
                 results_seen, stroke_events, drag_updates);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
